// ----- rtl/core/tct_pkg.sv -----
package tct_pkg;

  // fixed widths of the word fields
  localparam int COORD_W = 16;
  localparam int SLOT_W  = 3;

  // func codes of an input word
  localparam logic [1:0] FUNC_POINT     = 2'd0;
  localparam logic [1:0] FUNC_FRAME_END = 2'd1;
  localparam logic [1:0] FUNC_CANCEL    = 2'd2;

  // event kinds of a result word
  localparam logic [1:0] KIND_DOWN   = 2'd0;
  localparam logic [1:0] KIND_MOVE   = 2'd1;
  localparam logic [1:0] KIND_UP     = 2'd2;
  localparam logic [1:0] KIND_CANCEL = 2'd3;

  typedef struct packed {
    logic [1:0]         func;
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         event_kind;
    logic [SLOT_W-1:0]  slot_index;
    logic [COORD_W-1:0] event_x;
    logic [COORD_W-1:0] event_y;
    logic               last;
  } out_word_t;

  // classified command handed from front to back
  typedef enum logic [1:0] {
    CMD_POINT,
    CMD_FRAME_END,
    CMD_CANCEL
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } cmd_t;

  // back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_UP,
    ST_DOWN,
    ST_CANCEL,
    ST_FINISH
  } back_state_t;

endpackage

// ----- rtl/core/tct_fifo.sv -----
module tct_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  // handshake and pointer update
  always_comb begin
    full       = (cnt_r == CNT_FULL);
    empty      = (cnt_r == '0);
    do_push    = push && !full;
    do_pop     = pop && !empty;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  assign rdata = mem[rd_ptr_r];

endmodule

// ----- rtl/core/tct_front.sv -----
module tct_front #(
  parameter int MAX_SLOTS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  input  tct_pkg::in_word_t in_word,
  input  logic             q_full,
  output logic             q_push,
  output tct_pkg::cmd_t    q_word
);

  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SLOTS);

  logic [CNT_W-1:0] pt_cnt_r, pt_cnt_nxt;
  logic             accept;

  // classify words, count points of the current frame
  always_comb begin
    accept        = in_push && !q_full;
    q_push        = 1'b0;
    pt_cnt_nxt    = pt_cnt_r;
    q_word.kind   = tct_pkg::CMD_POINT;
    q_word.x      = in_word.point_x;
    q_word.y      = in_word.point_y;
    unique case (in_word.func)
      tct_pkg::FUNC_POINT: begin
        if (pt_cnt_r != CNT_MAX) begin
          q_push = accept;
          if (accept) begin
            pt_cnt_nxt = pt_cnt_r + 1'b1;
          end
        end
      end
      tct_pkg::FUNC_FRAME_END: begin
        q_word.kind = tct_pkg::CMD_FRAME_END;
        q_push      = accept;
        if (accept) begin
          pt_cnt_nxt = '0;
        end
      end
      tct_pkg::FUNC_CANCEL: begin
        q_word.kind = tct_pkg::CMD_CANCEL;
        q_push      = accept;
        if (accept) begin
          pt_cnt_nxt = '0;
        end
      end
      default: begin
        // unused code is taken and dropped
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_cnt_r <= '0;
    end else begin
      pt_cnt_r <= pt_cnt_nxt;
    end
  end

endmodule

// ----- rtl/core/tct_back.sv -----
module tct_back #(
  parameter int MAX_SLOTS  = 8,
  parameter int COORD_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_empty,
  output logic               cmd_pop,
  input  tct_pkg::cmd_t      cmd_word,
  input  logic               out_full,
  output logic               out_push,
  output tct_pkg::out_word_t out_data
);

  localparam int IDX_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int DIST_W = SQ_W + 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SLOTS);

  tct_pkg::back_state_t state_r, state_nxt;

  // current command
  tct_pkg::cmd_kind_t    cur_kind_r;
  logic [COORD_BITS-1:0] cur_x_r, cur_y_r;

  // slot table and pending points
  logic [COORD_BITS-1:0] slot_x_r [MAX_SLOTS];
  logic [COORD_BITS-1:0] slot_y_r [MAX_SLOTS];
  logic [COORD_BITS-1:0] pend_x_r [MAX_SLOTS];
  logic [COORD_BITS-1:0] pend_y_r [MAX_SLOTS];
  logic [MAX_SLOTS-1:0]  active_r, active_nxt;
  logic [MAX_SLOTS-1:0]  matched_r, matched_nxt;
  logic [CNT_W-1:0]      pend_cnt_r, pend_cnt_nxt;

  // scan counters
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] pidx_r, pidx_nxt;
  logic [IDX_W-1:0] scan_i;
  logic [IDX_W-1:0] pend_i;

  // distance pipeline
  logic                  p1_v_r, p1_v_nxt;
  logic                  p1_elig_r, p1_elig_nxt;
  logic [IDX_W-1:0]      p1_idx_r, p1_idx_nxt;
  logic [SQ_W-1:0]       sqx_r, sqx_nxt;
  logic [SQ_W-1:0]       sqy_r, sqy_nxt;
  logic [COORD_BITS-1:0] rd_x, rd_y, dx, dy;
  logic [DIST_W-1:0]     cand_d;
  logic                  found_r, found_nxt;
  logic [IDX_W-1:0]      best_idx_r, best_idx_nxt;
  logic [DIST_W-1:0]     best_d_r, best_d_nxt;

  // free slot search
  logic             free_any;
  logic [IDX_W-1:0] free_idx;

  // slot and pending writes
  logic                  slot_we;
  logic [IDX_W-1:0]      slot_wa;
  logic [COORD_BITS-1:0] slot_wx, slot_wy;
  logic                  pend_we;

  // event emission through a one-word hold stage, so last is known on flush
  logic                  emit_req;
  logic [1:0]            emit_kind;
  logic [IDX_W-1:0]      emit_slot;
  logic [COORD_BITS-1:0] emit_x, emit_y;
  logic                  can_emit;
  logic                  ev_v_r, ev_v_nxt;
  tct_pkg::out_word_t    ev_r, ev_nxt;

  assign scan_i   = idx_r[IDX_W-1:0];
  assign pend_i   = pidx_r[IDX_W-1:0];
  assign can_emit = !ev_v_r || !out_full;

  // distance of the scanned slot
  always_comb begin
    rd_x   = slot_x_r[scan_i];
    rd_y   = slot_y_r[scan_i];
    dx     = (cur_x_r >= rd_x) ? cur_x_r - rd_x : rd_x - cur_x_r;
    dy     = (cur_y_r >= rd_y) ? cur_y_r - rd_y : rd_y - cur_y_r;
    cand_d = DIST_W'(sqx_r) + DIST_W'(sqy_r);
  end

  // lowest inactive slot
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tct_pkg::ST_IDLE: begin
        if (!cmd_empty) begin
          unique case (cmd_word.kind)
            tct_pkg::CMD_POINT:     state_nxt = tct_pkg::ST_SCAN;
            tct_pkg::CMD_FRAME_END: state_nxt = tct_pkg::ST_UP;
            tct_pkg::CMD_CANCEL:    state_nxt = tct_pkg::ST_CANCEL;
            default:                state_nxt = tct_pkg::ST_FINISH;
          endcase
        end
      end
      tct_pkg::ST_SCAN: begin
        if (idx_r == CNT_MAX && !p1_v_r) begin
          state_nxt = tct_pkg::ST_APPLY;
        end
      end
      tct_pkg::ST_APPLY: begin
        if (!emit_req || can_emit) begin
          state_nxt = tct_pkg::ST_FINISH;
        end
      end
      tct_pkg::ST_UP: begin
        if (idx_r == CNT_MAX) begin
          state_nxt = tct_pkg::ST_DOWN;
        end
      end
      tct_pkg::ST_DOWN: begin
        if (pidx_r == pend_cnt_r) begin
          state_nxt = tct_pkg::ST_FINISH;
        end
      end
      tct_pkg::ST_CANCEL: begin
        if (idx_r == CNT_MAX) begin
          state_nxt = tct_pkg::ST_FINISH;
        end
      end
      tct_pkg::ST_FINISH: begin
        if (can_emit) begin
          state_nxt = tct_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tct_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_pop      = 1'b0;
    out_push     = 1'b0;
    out_data     = ev_r;
    active_nxt   = active_r;
    matched_nxt  = matched_r;
    pend_cnt_nxt = pend_cnt_r;
    idx_nxt      = idx_r;
    pidx_nxt     = pidx_r;
    p1_v_nxt     = p1_v_r;
    p1_elig_nxt  = p1_elig_r;
    p1_idx_nxt   = p1_idx_r;
    sqx_nxt      = sqx_r;
    sqy_nxt      = sqy_r;
    found_nxt    = found_r;
    best_idx_nxt = best_idx_r;
    best_d_nxt   = best_d_r;
    slot_we      = 1'b0;
    slot_wa      = best_idx_r;
    slot_wx      = cur_x_r;
    slot_wy      = cur_y_r;
    pend_we      = 1'b0;
    emit_req     = 1'b0;
    emit_kind    = tct_pkg::KIND_DOWN;
    emit_slot    = '0;
    emit_x       = '0;
    emit_y       = '0;
    ev_v_nxt     = ev_v_r;
    ev_nxt       = ev_r;

    unique case (state_r)
      tct_pkg::ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop   = 1'b1;
          idx_nxt   = '0;
          pidx_nxt  = '0;
          found_nxt = 1'b0;
          p1_v_nxt  = 1'b0;
        end
      end

      tct_pkg::ST_SCAN: begin
        // issue: squares of one slot per cycle
        if (idx_r != CNT_MAX) begin
          p1_v_nxt    = 1'b1;
          p1_idx_nxt  = scan_i;
          p1_elig_nxt = active_r[scan_i] && !matched_r[scan_i];
          sqx_nxt     = dx * dx;
          sqy_nxt     = dy * dy;
          idx_nxt     = idx_r + 1'b1;
        end else begin
          p1_v_nxt = 1'b0;
        end
        // compare: strict less keeps the lowest slot on a tie
        if (p1_v_r && p1_elig_r && (!found_r || cand_d < best_d_r)) begin
          found_nxt    = 1'b1;
          best_idx_nxt = p1_idx_r;
          best_d_nxt   = cand_d;
        end
      end

      tct_pkg::ST_APPLY: begin
        if (found_r) begin
          // zero distance means the position did not change
          emit_req  = (best_d_r != '0);
          emit_kind = tct_pkg::KIND_MOVE;
          emit_slot = best_idx_r;
          emit_x    = cur_x_r;
          emit_y    = cur_y_r;
          if (!emit_req || can_emit) begin
            slot_we                 = 1'b1;
            matched_nxt[best_idx_r] = 1'b1;
          end
        end else if (pend_cnt_r != CNT_MAX) begin
          pend_we      = 1'b1;
          pend_cnt_nxt = pend_cnt_r + 1'b1;
        end
      end

      tct_pkg::ST_UP: begin
        if (idx_r != CNT_MAX) begin
          if (active_r[scan_i] && !matched_r[scan_i]) begin
            emit_req  = 1'b1;
            emit_kind = tct_pkg::KIND_UP;
            emit_slot = scan_i;
            emit_x    = rd_x;
            emit_y    = rd_y;
            if (can_emit) begin
              active_nxt[scan_i] = 1'b0;
              idx_nxt            = idx_r + 1'b1;
            end
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end

      tct_pkg::ST_DOWN: begin
        if (pidx_r != pend_cnt_r) begin
          if (free_any) begin
            emit_req  = 1'b1;
            emit_kind = tct_pkg::KIND_DOWN;
            emit_slot = free_idx;
            emit_x    = pend_x_r[pend_i];
            emit_y    = pend_y_r[pend_i];
            if (can_emit) begin
              slot_we              = 1'b1;
              slot_wa              = free_idx;
              slot_wx              = pend_x_r[pend_i];
              slot_wy              = pend_y_r[pend_i];
              active_nxt[free_idx] = 1'b1;
              pidx_nxt             = pidx_r + 1'b1;
            end
          end else begin
            // no free slot: point is dropped
            pidx_nxt = pidx_r + 1'b1;
          end
        end
      end

      tct_pkg::ST_CANCEL: begin
        if (idx_r != CNT_MAX) begin
          if (active_r[scan_i]) begin
            emit_req  = 1'b1;
            emit_kind = tct_pkg::KIND_CANCEL;
            emit_slot = scan_i;
            emit_x    = rd_x;
            emit_y    = rd_y;
            if (can_emit) begin
              active_nxt[scan_i] = 1'b0;
              idx_nxt            = idx_r + 1'b1;
            end
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end

      tct_pkg::ST_FINISH: begin
        if (can_emit) begin
          // flush the held word as the last one of this command
          if (ev_v_r) begin
            out_push      = 1'b1;
            out_data.last = 1'b1;
            ev_v_nxt      = 1'b0;
          end
          if (cur_kind_r != tct_pkg::CMD_POINT) begin
            matched_nxt  = '0;
            pend_cnt_nxt = '0;
          end
        end
      end

      default: begin
      end
    endcase

    // a new event pushes out the held one, which is then not last
    if (emit_req && can_emit) begin
      if (ev_v_r) begin
        out_push      = 1'b1;
        out_data.last = 1'b0;
      end
      ev_v_nxt          = 1'b1;
      ev_nxt.event_kind = emit_kind;
      ev_nxt.slot_index = tct_pkg::SLOT_W'(emit_slot);
      ev_nxt.event_x    = tct_pkg::COORD_W'(emit_x);
      ev_nxt.event_y    = tct_pkg::COORD_W'(emit_y);
      ev_nxt.last       = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= tct_pkg::ST_IDLE;
      active_r   <= '0;
      matched_r  <= '0;
      pend_cnt_r <= '0;
      idx_r      <= '0;
      pidx_r     <= '0;
      p1_v_r     <= 1'b0;
      found_r    <= 1'b0;
      ev_v_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      active_r   <= active_nxt;
      matched_r  <= matched_nxt;
      pend_cnt_r <= pend_cnt_nxt;
      idx_r      <= idx_nxt;
      pidx_r     <= pidx_nxt;
      p1_v_r     <= p1_v_nxt;
      found_r    <= found_nxt;
      ev_v_r     <= ev_v_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    p1_elig_r  <= p1_elig_nxt;
    p1_idx_r   <= p1_idx_nxt;
    sqx_r      <= sqx_nxt;
    sqy_r      <= sqy_nxt;
    best_idx_r <= best_idx_nxt;
    best_d_r   <= best_d_nxt;
    ev_r       <= ev_nxt;
    if (cmd_pop) begin
      cur_kind_r <= cmd_word.kind;
      cur_x_r    <= cmd_word.x[COORD_BITS-1:0];
      cur_y_r    <= cmd_word.y[COORD_BITS-1:0];
    end
  end

  // slot table and pending list writes
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_x_r[slot_wa] <= slot_wx;
      slot_y_r[slot_wa] <= slot_wy;
    end
    if (pend_we) begin
      pend_x_r[pend_cnt_r[IDX_W-1:0]] <= cur_x_r;
      pend_y_r[pend_cnt_r[IDX_W-1:0]] <= cur_y_r;
    end
  end

endmodule

// ----- rtl/core/touch_contact_tracker_unit.sv -----
// Multitouch contact tracker. Touch points, frame ends and cancels go in as words through
// push/full; down, move, up and cancel events come out as words through empty/pop, the last
// word caused by an input marked with last. Each point is matched to the nearest active,
// not yet matched slot (squared distance, lowest slot on a tie); points that find no slot
// take free slots at frame end, after the ups. Inputs land in a two-word command queue, so a
// few can be taken while the engine works. For a point the engine runs a distance scan that
// visits one slot per cycle through a square-and-compare pipe; a frame end scans the slots
// for ups and then places the pending points, and a cancel scans the slots; the result side
// can stall each of them. Points past MAX_SLOTS in one frame and func code 3 are
// taken and dropped without an event.
module touch_contact_tracker_unit #(
  parameter int MAX_SLOTS  = 8,
  parameter int COORD_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  tct_pkg::in_word_t  in_word,
  output logic               empty,
  input  logic               pop,
  output tct_pkg::out_word_t out_word
);

  tct_pkg::cmd_t      q_word;
  logic               q_push;
  logic               q_full;
  logic [$bits(tct_pkg::cmd_t)-1:0] c_bits;
  tct_pkg::cmd_t      c_word;
  logic               c_empty;
  logic               c_pop;
  tct_pkg::out_word_t r_word;
  logic               r_push;
  logic               r_full;

  assign full   = q_full;
  assign c_word = tct_pkg::cmd_t'(c_bits);

  // front: classify and count points
  tct_front #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (push),
    .in_word (in_word),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_word  (q_word)
  );

  // command queue between front and back
  tct_fifo #(
    .WIDTH ($bits(tct_pkg::cmd_t)),
    .DEPTH (2)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_word),
    .full  (q_full),
    .pop   (c_pop),
    .rdata (c_bits),
    .empty (c_empty)
  );

  // back: slot table engine
  tct_back #(
    .MAX_SLOTS  (MAX_SLOTS),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (c_empty),
    .cmd_pop   (c_pop),
    .cmd_word  (c_word),
    .out_full  (r_full),
    .out_push  (r_push),
    .out_data  (r_word)
  );

  // result queue
  tct_fifo #(
    .WIDTH ($bits(tct_pkg::out_word_t)),
    .DEPTH (2)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (r_push),
    .wdata (r_word),
    .full  (r_full),
    .pop   (pop),
    .rdata (out_word),
    .empty (empty)
  );

endmodule

// ----- rtl/core/tct_checker.sv -----
module tct_checker #(
  parameter int MAX_SLOTS  = 8,
  parameter int COORD_BITS = 16
) (
  input logic               clk,
  input logic               rst_n,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input tct_pkg::out_word_t out_word
);

  // reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result side not empty after reset");

  // reset leaves the input side open
  a_reset_open: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("input side full after reset");

  // a waiting word holds until popped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_word)))
    else $error("waiting result word changed");

  // events name a slot that exists
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && MAX_SLOTS <= 8) |-> (32'(out_word.slot_index) < MAX_SLOTS))
    else $error("event slot out of range");

  // reported coordinates stay inside the coordinate width
  a_coord_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> ((32'(out_word.event_x) >> COORD_BITS) == 0 &&
                (32'(out_word.event_y) >> COORD_BITS) == 0))
    else $error("event coordinate wider than coordinate width");

endmodule

bind touch_contact_tracker_unit tct_checker #(
  .MAX_SLOTS  (MAX_SLOTS),
  .COORD_BITS (COORD_BITS)
) u_tct_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_word (out_word)
);

// ----- tb/touch_contact_tracker_checker.sv -----
module touch_contact_tracker_checker
  import tct_pkg::*;
#(
  parameter int MAX_SLOTS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  logic      full,
  input  in_word_t  in_word,
  input  logic      empty,
  input  logic      pop,
  input  out_word_t out_word,
  output int        fail_count,
  output int        waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  // tracker state kept beside the block
  logic [COORD_W-1:0] contact_x     [MAX_SLOTS];
  logic [COORD_W-1:0] contact_y     [MAX_SLOTS];
  logic               contact_live  [MAX_SLOTS];
  logic               contact_taken [MAX_SLOTS];
  logic [COORD_W-1:0] held_x        [MAX_SLOTS];
  logic [COORD_W-1:0] held_y        [MAX_SLOTS];
  int                 held_count;
  int                 frame_points;

  out_word_t expected_events[$];
  int        mismatches;

  assign fail_count = mismatches;
  assign waiting    = expected_events.size();

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic add_event(input logic [1:0] kind, input int slot,
                           input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    out_word_t ev;
    ev.event_kind = kind;
    ev.slot_index = SLOT_W'(slot);
    ev.event_x    = x;
    ev.event_y    = y;
    ev.last       = 1'b0;
    expected_events.push_back(ev);
  endtask

  task automatic clear_frame();
    int s;
    for (s = 0; s < MAX_SLOTS; s++) contact_taken[s] = 1'b0;
    held_count   = 0;
    frame_points = 0;
  endtask

  // work out the events one input word causes
  task automatic track_word(input in_word_t w);
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic               found;
    logic               placed;
    int                 best;
    logic [33:0]        best_d;
    logic [33:0]        d;
    logic [33:0]        dx;
    logic [33:0]        dy;
    int                 first_new;
    int                 s;
    int                 p;
    px        = w.point_x;
    py        = w.point_y;
    first_new = expected_events.size();
    case (w.func)
      FUNC_POINT: begin
        if (frame_points < MAX_SLOTS) begin
          frame_points++;
          found  = 1'b0;
          best   = 0;
          best_d = '0;
          // nearest free live contact, lowest slot on a tie
          for (s = 0; s < MAX_SLOTS; s++) begin
            if (contact_live[s] && !contact_taken[s]) begin
              dx = (contact_x[s] >= px) ? 34'(contact_x[s] - px) : 34'(px - contact_x[s]);
              dy = (contact_y[s] >= py) ? 34'(contact_y[s] - py) : 34'(py - contact_y[s]);
              d  = dx * dx + dy * dy;
              if (!found || d < best_d) begin
                found  = 1'b1;
                best   = s;
                best_d = d;
              end
            end
          end
          if (found) begin
            contact_taken[best] = 1'b1;
            if (contact_x[best] != px || contact_y[best] != py) begin
              add_event(KIND_MOVE, best, px, py);
            end
            contact_x[best] = px;
            contact_y[best] = py;
          end else if (held_count < MAX_SLOTS) begin
            held_x[held_count] = px;
            held_y[held_count] = py;
            held_count++;
          end
        end
      end
      FUNC_FRAME_END: begin
        // lifts first, then new contacts into the lowest free slots
        for (s = 0; s < MAX_SLOTS; s++) begin
          if (contact_live[s] && !contact_taken[s]) begin
            add_event(KIND_UP, s, contact_x[s], contact_y[s]);
            contact_live[s] = 1'b0;
          end
        end
        for (p = 0; p < held_count; p++) begin
          placed = 1'b0;
          for (s = 0; s < MAX_SLOTS; s++) begin
            if (!placed && !contact_live[s]) begin
              contact_x[s]    = held_x[p];
              contact_y[s]    = held_y[p];
              contact_live[s] = 1'b1;
              add_event(KIND_DOWN, s, held_x[p], held_y[p]);
              placed = 1'b1;
            end
          end
        end
        clear_frame();
      end
      FUNC_CANCEL: begin
        for (s = 0; s < MAX_SLOTS; s++) begin
          if (contact_live[s]) begin
            add_event(KIND_CANCEL, s, contact_x[s], contact_y[s]);
            contact_live[s] = 1'b0;
          end
        end
        clear_frame();
      end
      default: begin
      end
    endcase
    if (expected_events.size() > first_new) begin
      expected_events[expected_events.size() - 1].last = 1'b1;
    end
  endtask

  // compare popped words, then predict from pushed words
  always @(posedge clk) begin
    out_word_t want;
    int        s;
    if (!rst_n) begin
      for (s = 0; s < MAX_SLOTS; s++) begin
        contact_x[s]     = '0;
        contact_y[s]     = '0;
        contact_live[s]  = 1'b0;
        contact_taken[s] = 1'b0;
        held_x[s]        = '0;
        held_y[s]        = '0;
      end
      held_count   = 0;
      frame_points = 0;
    end else begin
      if (pop && !empty) begin
        if (expected_events.size() == 0) begin
          report_mismatch("unexpected word", 64'(out_word), '0);
        end else begin
          want = expected_events.pop_front();
          if (out_word.event_kind !== want.event_kind)
            report_mismatch("event_kind", 64'(out_word.event_kind), 64'(want.event_kind));
          if (out_word.slot_index !== want.slot_index)
            report_mismatch("slot_index", 64'(out_word.slot_index), 64'(want.slot_index));
          if (out_word.event_x !== want.event_x)
            report_mismatch("event_x", 64'(out_word.event_x), 64'(want.event_x));
          if (out_word.event_y !== want.event_y)
            report_mismatch("event_y", 64'(out_word.event_y), 64'(want.event_y));
          if (out_word.last !== want.last)
            report_mismatch("last", 64'(out_word.last), 64'(want.last));
        end
      end
      if (push && !full) begin
        track_word(in_word);
      end
    end
  end

  initial begin
    mismatches = 0;
  end

endmodule

// ----- tb/touch_contact_tracker_unit_tb.sv -----
module touch_contact_tracker_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tct_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int N_SLOTS      = 8;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 100;
  localparam int PHASE_ITEMS  = 95;

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      push    = 1'b0;
  logic      pop     = 1'b0;
  in_word_t  in_word = '0;
  logic      full;
  logic      empty;
  out_word_t out_word;
  int        fail_count;
  int        waiting;

  int   idle_pct  = 0;
  int   stall_pct = 0;
  logic hold_off  = 1'b0;
  int   words_sent = 0;

  // points of the previous frame, reused with jitter to keep contacts alive
  logic [15:0] prev_x [N_SLOTS];
  logic [15:0] prev_y [N_SLOTS];
  int          prev_n = 0;

  touch_contact_tracker_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_word  (in_word),
    .empty    (empty),
    .pop      (pop),
    .out_word (out_word)
  );

  touch_contact_tracker_checker #(
    .MAX_SLOTS (N_SLOTS)
  ) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_word    (in_word),
    .empty      (empty),
    .pop        (pop),
    .out_word   (out_word),
    .fail_count (fail_count),
    .waiting    (waiting)
  );

  always #5 clk = ~clk;

  // offer one word, with a random gap first
  task automatic send_word(input logic [1:0] func, input logic [15:0] x,
                           input logic [15:0] y);
    if ($urandom_range(0, 99) < idle_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    push    <= 1'b1;
    in_word <= '{func: func, point_x: x, point_y: y};
    do @(posedge clk); while (full);
    words_sent++;
  endtask

  task automatic send_point(input logic [15:0] x, input logic [15:0] y);
    send_word(FUNC_POINT, x, y);
  endtask

  // non-point words carry random coordinates
  task automatic send_cmd(input logic [1:0] func);
    send_word(func, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
  endtask

  // one frame: mostly tracked contacts with jitter, some fresh points and noise
  task automatic random_frame();
    logic [15:0] cur_x [N_SLOTS];
    logic [15:0] cur_y [N_SLOTS];
    logic [15:0] x;
    logic [15:0] y;
    int          n_points;
    int          k;
    int          pick;
    n_points = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 10) : $urandom_range(0, 5);
    for (k = 0; k < n_points; k++) begin
      if (k < prev_n && $urandom_range(0, 3) != 0) begin
        x = prev_x[k];
        y = prev_y[k];
        if ($urandom_range(0, 3) != 0) begin
          x = x + 16'($urandom_range(0, 64)) - 16'd32;
          y = y + 16'($urandom_range(0, 64)) - 16'd32;
        end
      end else if ($urandom_range(0, 7) == 0) begin
        x = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
        y = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
      end else begin
        x = 16'($urandom_range(0, 65535));
        y = 16'($urandom_range(0, 65535));
      end
      if (k < N_SLOTS) begin
        cur_x[k] = x;
        cur_y[k] = y;
      end
      if ($urandom_range(0, 29) == 0) send_cmd(FUNC_UNUSED);
      send_point(x, y);
    end
    prev_n = (n_points > N_SLOTS) ? N_SLOTS : n_points;
    for (k = 0; k < prev_n; k++) begin
      prev_x[k] = cur_x[k];
      prev_y[k] = cur_y[k];
    end
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      send_cmd(FUNC_CANCEL);
      prev_n = 0;
    end else begin
      if (pick < 9) send_cmd(FUNC_UNUSED);
      send_cmd(FUNC_FRAME_END);
    end
  endtask

  // result side: random stalls, and one long hold-off on request
  initial begin
    int hold_count;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        pop <= 1'b0;
        for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) @(posedge clk);
        hold_off = 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // main stimulus and verdict
  initial begin
    int idle_tab  [4];
    int stall_tab [4];
    int directed_count;
    int phase;
    int k;
    idle_tab  = '{0, 54, 0, 34};
    stall_tab = '{0, 0, 54, 34};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // quiet words on an empty table
    send_cmd(FUNC_CANCEL);
    send_cmd(FUNC_UNUSED);
    send_cmd(FUNC_FRAME_END);
    // two new contacts at the corners
    send_point(16'h0000, 16'h0000);
    send_point(16'hffff, 16'hffff);
    send_cmd(FUNC_FRAME_END);
    // unchanged point gives no move, second one moves
    send_point(16'h0000, 16'h0000);
    send_point(16'hffff, 16'h0000);
    send_cmd(FUNC_FRAME_END);
    // one contact moves, the other lifts
    send_point(16'd10, 16'd0);
    send_cmd(FUNC_FRAME_END);
    // tie between two contacts goes to the lower slot
    send_point(16'd10, 16'd0);
    send_point(16'd30, 16'd0);
    send_cmd(FUNC_FRAME_END);
    send_point(16'd20, 16'd0);
    send_cmd(FUNC_FRAME_END);
    // too many points in one frame, then cancel a full table
    for (k = 0; k < N_SLOTS + 1; k++) begin
      send_point(16'(k * 8000), 16'(65535 - k * 8000));
    end
    send_cmd(FUNC_FRAME_END);
    send_cmd(FUNC_CANCEL);
    directed_count = words_sent;

    for (phase = 0; phase < 4; phase++) begin
      idle_pct  = idle_tab[phase];
      stall_pct = stall_tab[phase];
      if (phase == 0) hold_off = 1'b1;
      while (words_sent < directed_count + (phase + 1) * PHASE_ITEMS) begin
        random_frame();
      end
    end
    push <= 1'b0;
    stall_pct = 0;

    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && waiting == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // run limit
  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
